### src/linear_probe_hash_table_top_assert.svh
// assertion macros for the hash table rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed");

// next-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

### src/lpht_pkg.sv
// shared types and constants of the linear probing hash table
// no dependencies; imported by every rtl module of the block
`default_nettype none

package lpht_pkg;

  // field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  // table geometry and register reset
  localparam int unsigned CAPACITY_DEFAULT = 1024;
  localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 11'd512;

  // hash: low key word plus seed times multiplier, magnitude, reduced per digit
  localparam int unsigned HASH_SEED   = 10;
  localparam int unsigned HASH_MULT   = 37;
  localparam int unsigned MAG_W       = 32;
  localparam logic [MAG_W-1:0] HASH_OFFSET = MAG_W'(HASH_SEED * HASH_MULT);
  localparam int unsigned HASH_BITS   = 8;
  localparam int unsigned HASH_STEPS  = MAG_W / HASH_BITS;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } back_state_e;

  // one classified operation as it travels from front to back
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              zero_key;
  } op_t;

endpackage

`default_nettype wire

### src/linear_probe_hash_table_top.sv
// the single read port probes one slot a cycle; a finished probe holds while the result
//   register is still full
// hashing, one remainder digit per step, overlaps the probe of the previous item
// reset: a clearing pass over all CAPACITY slots zeroes the key memory, input ready low
// top level of the hash table; depends on lpht_pkg, lpht_front, lpht_queue, lpht_back
`default_nettype none

module linear_probe_hash_table_top #(
  parameter int unsigned CAPACITY = lpht_pkg::CAPACITY_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpht_pkg::FUNC_W-1:0]   func_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    entry_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpht_pkg::STATUS_W-1:0] status_o,
  output logic [lpht_pkg::VAL_W-1:0]    found_value_o,
  output logic [lpht_pkg::COUNT_W-1:0]  occupancy_o,
  input  logic                          cfg_we_i,
  input  logic [lpht_pkg::COUNT_W-1:0]  cfg_wdata_i
);
  import lpht_pkg::*;

  localparam int unsigned SlotW = $clog2(CAPACITY);

  logic             clear_busy;
  logic             q_full, q_push, q_valid, q_pop;
  op_t              push_op, head_op;
  logic [SlotW-1:0] push_home, head_home;

  // front: accept and hash
  lpht_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .entry_value_i (entry_value_i),
    .clear_busy_i  (clear_busy),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_op_o     (push_op),
    .push_home_o   (push_home)
  );

  // queue between the two halves
  lpht_queue #(.SlotW(SlotW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_op_i   (push_op),
    .push_home_i (push_home),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_op_o   (head_op),
    .head_home_o (head_home)
  );

  // back: probe the table and deliver results
  lpht_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .clear_busy_o  (clear_busy),
    .q_valid_i     (q_valid),
    .q_op_i        (head_op),
    .q_home_i      (head_home),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

`default_nettype wire

### src/lpht_front.sv
// front end: accepts transactions, flags zero keys, computes the home slot
// depends on lpht_pkg
`default_nettype none

module lpht_front #(
  parameter int unsigned CAPACITY = lpht_pkg::CAPACITY_DEFAULT,
  localparam int unsigned SlotW = $clog2(CAPACITY)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lpht_pkg::FUNC_W-1:0] func_i,
  input  logic [lpht_pkg::KEY_W-1:0]  key_i,
  input  logic [lpht_pkg::VAL_W-1:0]  entry_value_i,
  input  logic                       clear_busy_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output lpht_pkg::op_t              push_op_o,
  output logic [SlotW-1:0]           push_home_o
);
  import lpht_pkg::*;

  localparam int unsigned StepW = $clog2(HASH_STEPS);
  localparam logic [SlotW:0] CapW = (SlotW+1)'(CAPACITY);

  front_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [SlotW-1:0] rem_q, rem_d;
  op_t              op_q, op_d;
  logic [MAG_W-1:0] sum;
  logic             accept;

  // one digit of remainder reduction, msb first
  function automatic logic [SlotW-1:0] reduce_digit(input logic [SlotW-1:0] rem,
                                                    input logic [HASH_BITS-1:0] digit);
    logic [SlotW:0] r;
    r = {1'b0, rem};
    for (int i = HASH_BITS - 1; i >= 0; i--) begin
      r = {r[SlotW-1:0], digit[i]};
      if (r >= CapW) begin
        r = r - CapW;
      end
    end
    return r[SlotW-1:0];
  endfunction

  assign sum    = key_i[MAG_W-1:0] + HASH_OFFSET;
  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    op_q   <= op_d;
  end

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    mag_d      = mag_q;
    rem_d      = rem_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = !clear_busy_i;
        if (accept) begin
          op_d.func     = func_i;
          op_d.key      = key_i;
          op_d.value    = entry_value_i;
          op_d.zero_key = (key_i == '0);
          mag_d         = sum[MAG_W-1] ? (~sum + 1'b1) : sum;
          rem_d         = '0;
          step_d        = '0;
          state_d       = F_HASH;
        end
      end
      F_HASH: begin
        rem_d  = reduce_digit(rem_q, mag_q[MAG_W-1 -: HASH_BITS]);
        mag_d  = mag_q << HASH_BITS;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(HASH_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        push_o = !q_full_i;
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign push_op_o   = op_q;
  assign push_home_o = rem_q;

endmodule

`default_nettype wire

### src/lpht_queue.sv
// short fifo of classified operations between front and back
// depends on lpht_pkg
`default_nettype none

module lpht_queue #(
  parameter int unsigned SlotW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpht_pkg::op_t    push_op_i,
  input  logic [SlotW-1:0] push_home_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lpht_pkg::op_t    head_op_o,
  output logic [SlotW-1:0] head_home_o
);
  import lpht_pkg::*;

  op_t              op_mem_q   [QUEUE_DEPTH];
  logic [SlotW-1:0] home_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o     = (cnt_q != '0);
  assign head_op_o   = op_mem_q[rd_ptr_q];
  assign head_home_o = home_mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      op_mem_q[wr_ptr_q]   <= push_op_i;
      home_mem_q[wr_ptr_q] <= push_home_i;
    end
  end

endmodule

`default_nettype wire

### src/lpht_back.sv
// back end: key and value memories, probe sequencer, result register
// depends on lpht_pkg and the assertion macro header
`default_nettype none
`include "linear_probe_hash_table_top_assert.svh"

module lpht_back #(
  parameter int unsigned CAPACITY = lpht_pkg::CAPACITY_DEFAULT,
  localparam int unsigned SlotW = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpht_pkg::COUNT_W-1:0]  cfg_wdata_i,
  output logic                          clear_busy_o,
  input  logic                          q_valid_i,
  input  lpht_pkg::op_t                 q_op_i,
  input  logic [SlotW-1:0]              q_home_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpht_pkg::STATUS_W-1:0] status_o,
  output logic [lpht_pkg::VAL_W-1:0]    found_value_o,
  output logic [lpht_pkg::COUNT_W-1:0]  occupancy_o
);
  import lpht_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);

  // table memories
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0] key_rdata_q;
  logic [VAL_W-1:0] val_rdata_q;

  back_state_e        state_q, state_d;
  logic [SlotW-1:0]   clr_addr_q, clr_addr_d;
  logic [SlotW-1:0]   cur_q, cur_d;
  logic [SlotW-1:0]   iss_q, iss_d;
  logic [SlotW-1:0]   n_q, n_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] load_limit_q;
  op_t                op_q, op_d;

  logic               out_valid_q;
  status_e            status_q;
  logic [VAL_W-1:0]   found_q;
  logic [COUNT_W-1:0] occ_q;

  logic               rd_en;
  logic [SlotW-1:0]   rd_addr;
  logic               key_we, val_we;
  logic [SlotW-1:0]   waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic               pop;
  logic               res_load;
  status_e            res_status;
  logic [VAL_W-1:0]   res_found;
  logic               out_free;
  logic               hit, empty, last, done;
  logic               do_key_wr, do_val_wr, do_inc, do_dec;
  status_e            probe_status;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : SlotW'(s + 1'b1);
  endfunction

  assign out_free     = !out_valid_q || out_ready_i;
  assign clear_busy_o = (state_q == B_CLEAR);
  assign q_pop_o      = pop;

  // memory ports: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[waddr] <= op_q.value;
    end
    if (rd_en) begin
      key_rdata_q <= key_mem[rd_addr];
      val_rdata_q <= val_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_CLEAR;
      clr_addr_q   <= '0;
      count_q      <= '0;
      load_limit_q <= LOAD_LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      count_q    <= count_d;
      if (cfg_we_i) begin
        load_limit_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // probe and result payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    iss_q <= iss_d;
    n_q   <= n_d;
    op_q  <= op_d;
    if (res_load) begin
      status_q <= res_status;
      found_q  <= res_found;
      occ_q    <= count_d;
    end
  end

  // slot check on the registered read data
  always_comb begin
    hit          = (key_rdata_q == op_q.key);
    empty        = (key_rdata_q == '0);
    last         = (n_q == LastSlot);
    done         = 1'b0;
    do_key_wr    = 1'b0;
    do_val_wr    = 1'b0;
    do_inc       = 1'b0;
    do_dec       = 1'b0;
    probe_status = ST_OK;
    case (op_q.func)
      FUNC_INSERT: begin
        if (empty) begin
          done      = 1'b1;
          do_key_wr = 1'b1;
          do_val_wr = 1'b1;
          do_inc    = 1'b1;
        end else if (hit) begin
          done         = 1'b1;
          probe_status = ST_DUP;
        end else if (last) begin
          done         = 1'b1;
          probe_status = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          done      = 1'b1;
          do_key_wr = 1'b1;
          do_dec    = (count_q != '0);
        end else if (last) begin
          done         = 1'b1;
          probe_status = ST_NOTFOUND;
        end
      end
      default: begin
        if (hit) begin
          done = 1'b1;
        end else if (last) begin
          done         = 1'b1;
          probe_status = ST_NOTFOUND;
        end
      end
    endcase
  end

  // sequencer: clearing pass, dispatch, one slot per cycle probing, held while a result waits for the result register
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    cur_d      = cur_q;
    iss_d      = iss_q;
    n_d        = n_q;
    count_d    = count_q;
    op_d       = op_q;
    rd_en      = 1'b0;
    rd_addr    = iss_q;
    key_we     = 1'b0;
    val_we     = 1'b0;
    waddr      = cur_q;
    key_wdata  = '0;
    pop        = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_found  = '0;
    case (state_q)
      B_CLEAR: begin
        key_we = 1'b1;
        waddr  = clr_addr_q;
        if (clr_addr_q == LastSlot) begin
          state_d = B_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          if (q_op_i.zero_key) begin
            // zero key answers at once and touches nothing
            if (out_free) begin
              pop        = 1'b1;
              res_load   = 1'b1;
              res_status = ST_ZERO;
            end
          end else if (q_op_i.func == FUNC_INSERT && count_q >= load_limit_q) begin
            // load limit refuses before any probe
            if (out_free) begin
              pop        = 1'b1;
              res_load   = 1'b1;
              res_status = ST_FULL;
            end
          end else begin
            pop     = 1'b1;
            op_d    = q_op_i;
            rd_en   = 1'b1;
            rd_addr = q_home_i;
            cur_d   = q_home_i;
            iss_d   = next_slot(q_home_i);
            n_d     = '0;
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        if (done) begin
          // hold the read data until the result register frees up
          if (out_free) begin
            res_load   = 1'b1;
            res_status = probe_status;
            if (op_q.func != FUNC_INSERT && op_q.func != FUNC_REMOVE &&
                probe_status == ST_OK) begin
              res_found = val_rdata_q;
            end
            key_we    = do_key_wr;
            val_we    = do_val_wr;
            key_wdata = (op_q.func == FUNC_INSERT) ? op_q.key : '0;
            if (do_inc) begin
              count_d = count_q + 1'b1;
            end else if (do_dec) begin
              count_d = count_q - 1'b1;
            end
            state_d = B_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = iss_q;
          cur_d   = iss_q;
          iss_d   = next_slot(iss_q);
          n_d     = n_q + 1'b1;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign occupancy_o   = occ_q;

  // checks
  `LPHT_ASSERT_IMPL(a_result_into_free_reg, clk_i, rst_ni, res_load, out_free)
  `LPHT_ASSERT_IMPL(a_no_pop_while_clearing, clk_i, rst_ni, state_q == B_CLEAR, !pop)
  `LPHT_ASSERT_IMPL(a_key_write_context, clk_i, rst_ni, key_we, state_q == B_CLEAR || res_load)
  `LPHT_ASSERT_NEXT(a_count_moves_with_result, clk_i, rst_ni, !res_load, $stable(count_q))

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for linear_probe_hash_table_top: directed and random table traffic
// keeps its own copy of the key and value stores and checks every result in order
// depends on lpht_pkg and linear_probe_hash_table_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int unsigned CAPACITY      = CAPACITY_DEFAULT;
  localparam logic [FUNC_W-1:0] FUNC_ALT_SEARCH = 2'd3;
  localparam logic [MAG_W-1:0] SEED_SUM = MAG_W'(HASH_SEED * HASH_MULT);
  localparam int unsigned CYCLE_LIMIT   = 6000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;

  typedef struct packed {
    status_e            status;
    logic [VAL_W-1:0]   found;
    logic [COUNT_W-1:0] occ;
  } result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [KEY_W-1:0]    key_i;
  logic [VAL_W-1:0]    entry_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [VAL_W-1:0]    found_value_o;
  logic [COUNT_W-1:0]  occupancy_o;
  logic                cfg_we_i;
  logic [COUNT_W-1:0]  cfg_wdata_i;

  // shadow copy of the table
  logic [KEY_W-1:0]    slot_key [CAPACITY];
  logic [VAL_W-1:0]    slot_val [CAPACITY];
  int unsigned         entries;
  logic [COUNT_W-1:0]  load_limit_q;

  result_t             pending_results [$];
  logic [KEY_W-1:0]    known_keys [$];
  bit                  idle_on;
  int unsigned         ready_hold;
  int unsigned         errors;
  int unsigned         items_sent;
  int unsigned         results_checked;
  int unsigned         status_seen [5];
  int unsigned         cycle_count;

  linear_probe_hash_table_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .occupancy_o   (occupancy_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_results.size());
      $display("linear_probe_hash_table_top verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // home slot: magnitude of the offset low word, modulo table size
  function automatic int unsigned home_of(logic [KEY_W-1:0] key);
    logic [MAG_W-1:0] sum;
    logic [MAG_W-1:0] mag;
    sum = key[MAG_W-1:0] + SEED_SUM;
    mag = sum[MAG_W-1] ? (~sum + 32'd1) : sum;
    return mag % CAPACITY;
  endfunction

  // random key whose home is the given slot, sum of either sign
  function automatic logic [KEY_W-1:0] key_homed_at(int unsigned slot);
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] sum;
    logic [KEY_W-1:0] k;
    mag = MAG_W'(slot) + MAG_W'(CAPACITY) * MAG_W'($urandom_range(0, 2097151));
    sum = ($urandom_range(0, 1) == 1) ? (~mag + 32'd1) : mag;
    k = {$urandom, sum - SEED_SUM};
    if (k == '0) k[KEY_W-1] = 1'b1;
    return k;
  endfunction

  // apply one operation to the shadow table and return its result
  function automatic result_t table_apply(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] val);
    result_t     r;
    int unsigned slot;
    int unsigned n;
    int          hit;
    bit          done;
    r.status = ST_OK;
    r.found  = '0;
    if (key == '0) begin
      r.status = ST_ZERO;
    end else if (fn == FUNC_INSERT) begin
      if (entries >= load_limit_q) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_FULL;
        slot = home_of(key);
        done = 1'b0;
        for (n = 0; n < CAPACITY && !done; n++) begin
          if (slot_key[slot] == '0) begin
            slot_key[slot] = key;
            slot_val[slot] = val;
            entries++;
            r.status = ST_OK;
            done = 1'b1;
          end else if (slot_key[slot] == key) begin
            r.status = ST_DUP;
            done = 1'b1;
          end else begin
            slot = (slot + 1) % CAPACITY;
          end
        end
      end
    end else begin
      // remove, search and the spare selector all look the key up first
      hit = -1;
      slot = home_of(key);
      for (n = 0; n < CAPACITY && hit < 0; n++) begin
        if (slot_key[slot] == key) hit = int'(slot);
        else slot = (slot + 1) % CAPACITY;
      end
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
      end else if (fn == FUNC_REMOVE) begin
        slot_key[hit] = '0;
        slot_val[hit] = '0;
        if (entries > 0) entries--;
      end else begin
        r.found = slot_val[hit];
      end
    end
    r.occ = COUNT_W'(entries);
    return r;
  endfunction

  // send one transaction, predict its result once accepted
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    key_i         <= key;
    entry_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(table_apply(fn, key, val));
    items_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_load_limit(input logic [COUNT_W-1:0] limit);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    load_limit_q = limit;
  endtask

  // output side backpressure in random bursts
  initial begin
    out_ready_i = 1'b0;
    ready_hold  = 0;
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (status_o < 5) status_seen[status_o]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d found %0h occupancy %0d", $time,
                 status_o, found_value_o, occupancy_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (found_value_o !== want.found) begin
          errors++;
          $display("%0t: found_value expected %0h actual %0h", $time, want.found,
                   found_value_o);
        end
        if (occupancy_o !== want.occ) begin
          errors++;
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy_o);
        end
      end
    end
  end

  // zero key on every selector, misses on an empty table
  task automatic test_zero_key();
    int unsigned f;
    for (f = 0; f < 4; f++) send_op(FUNC_W'(f), '0, rand64());
    send_op(FUNC_SEARCH, 64'd1, '0);
    send_op(FUNC_REMOVE, '1, '0);
  endtask

  // field extremes, duplicates, the spare selector, most negative sum, probe wrap
  task automatic test_basic_ops();
    logic [KEY_W-1:0] k_neg;
    logic [KEY_W-1:0] k_a;
    logic [KEY_W-1:0] k_b;
    k_neg = {32'h8000_0001, 32'h8000_0000 - SEED_SUM};
    k_a   = key_homed_at(CAPACITY - 1);
    k_b   = key_homed_at(CAPACITY - 1);
    send_op(FUNC_INSERT, '1, '0);
    send_op(FUNC_INSERT, k_neg, '1);
    send_op(FUNC_INSERT, '1, rand64());
    send_op(FUNC_SEARCH, '1, rand64());
    send_op(FUNC_ALT_SEARCH, k_neg, '0);
    // second key of the top slot wraps past slot 0, which holds k_neg
    send_op(FUNC_INSERT, k_a, rand64());
    send_op(FUNC_INSERT, k_b, rand64());
    send_op(FUNC_SEARCH, k_b, '0);
    send_op(FUNC_REMOVE, '1, '0);
    send_op(FUNC_SEARCH, '1, '0);
  endtask

  // a hole ahead of a stored key lets it be stored twice
  task automatic test_removal_holes();
    logic [KEY_W-1:0] k_a;
    logic [KEY_W-1:0] k_b;
    k_a = key_homed_at(CAPACITY / 2);
    k_b = key_homed_at(CAPACITY / 2);
    send_op(FUNC_INSERT, k_a, rand64());
    send_op(FUNC_INSERT, k_b, rand64());
    send_op(FUNC_REMOVE, k_a, '0);
    send_op(FUNC_INSERT, k_b, rand64());
    send_op(FUNC_SEARCH, k_b, '0);
    send_op(FUNC_REMOVE, k_b, '0);
    send_op(FUNC_SEARCH, k_b, '0);
  endtask

  // limit zero refuses all inserts, limit reached refuses even a stored key
  task automatic test_load_limit();
    logic [KEY_W-1:0] k_old;
    int unsigned      s;
    k_old = '1;
    for (s = 0; s < CAPACITY; s++)
      if (slot_key[s] != '0) k_old = slot_key[s];
    write_load_limit('0);
    send_op(FUNC_INSERT, key_homed_at($urandom_range(0, CAPACITY - 1)), rand64());
    write_load_limit(COUNT_W'(entries));
    send_op(FUNC_INSERT, k_old, rand64());
  endtask

  // random traffic on new and already seen keys, clustered to build chains
  task automatic test_random_mix(input int unsigned n_ops, input logic [COUNT_W-1:0] limit);
    logic [KEY_W-1:0] k;
    int unsigned      base;
    int unsigned      pick;
    int unsigned      roll;
    int unsigned      i;
    write_load_limit(limit);
    base = $urandom_range(0, CAPACITY - 1);
    for (i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      pick = (known_keys.size() > 0) ? $urandom_range(0, known_keys.size() - 1) : 0;
      if (roll < 40 || known_keys.size() == 0) begin
        if ($urandom_range(0, 3) == 0) k = key_homed_at($urandom_range(0, CAPACITY - 1));
        else k = key_homed_at((base + $urandom_range(0, 31)) % CAPACITY);
        known_keys.push_back(k);
        send_op(FUNC_INSERT, k, rand64());
      end else if (roll < 52) begin
        send_op(FUNC_INSERT, known_keys[pick], rand64());
      end else if (roll < 70) begin
        send_op(($urandom_range(0, 3) == 0) ? FUNC_ALT_SEARCH : FUNC_SEARCH,
                known_keys[pick], rand64());
      end else if (roll < 85) begin
        send_op(FUNC_REMOVE, known_keys[pick], rand64());
        if ($urandom_range(0, 3) != 0) known_keys.delete(pick);
      end else if (roll < 92) begin
        send_op(FUNC_W'($urandom_range(0, 3)), rand64(), rand64());
      end else if (roll < 96) begin
        send_op(FUNC_W'($urandom_range(0, 3)), '0, rand64());
      end else begin
        send_op(FUNC_SEARCH, key_homed_at((base + $urandom_range(0, 31)) % CAPACITY),
                rand64());
      end
    end
  endtask

  // fill every slot, then probe a completely full table
  task automatic test_fill_table();
    int unsigned s;
    idle_on = 1'b0;
    write_load_limit('1);
    for (s = 0; s < CAPACITY; s++)
      if (slot_key[s] == '0) send_op(FUNC_INSERT, key_homed_at(s), rand64());
    send_op(FUNC_INSERT, key_homed_at($urandom_range(0, CAPACITY - 1)), rand64());
    send_op(FUNC_SEARCH, key_homed_at($urandom_range(0, CAPACITY - 1)), '0);
    s = $urandom_range(0, CAPACITY - 1);
    send_op(FUNC_ALT_SEARCH, slot_key[s], '0);
    send_op(FUNC_REMOVE, slot_key[s], '0);
    send_op(FUNC_INSERT, key_homed_at($urandom_range(0, CAPACITY - 1)), rand64());
    // table full again and limit at capacity: refused before probing
    write_load_limit(COUNT_W'(CAPACITY));
    send_op(FUNC_INSERT, key_homed_at($urandom_range(0, CAPACITY - 1)), rand64());
    send_op(FUNC_SEARCH, slot_key[$urandom_range(0, CAPACITY - 1)], '0);
  endtask

  // main sequence
  initial begin
    in_valid_i      = 1'b0;
    func_i          = '0;
    key_i           = '0;
    entry_value_i   = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    rst_ni          = 1'b0;
    idle_on         = 1'b1;
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    cycle_count     = 0;
    entries         = 0;
    load_limit_q    = LOAD_LIMIT_RESET;
    foreach (slot_key[i]) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_key();
    test_basic_ops();
    test_removal_holes();
    test_load_limit();
    test_random_mix(75, 11'd700);
    test_random_mix(75, COUNT_W'($urandom_range(0, CAPACITY)));
    test_random_mix(75, 11'd24);
    test_random_mix(75, 11'd1023);
    test_fill_table();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d transactions sent, %0d results checked: ok %0d, duplicate %0d, not found %0d,",
             items_sent, results_checked, status_seen[ST_OK], status_seen[ST_DUP],
             status_seen[ST_NOTFOUND]);
    $display("full %0d, zero key %0d; load limits 0 to 2047, table filled to %0d entries",
             status_seen[ST_FULL], status_seen[ST_ZERO], entries);
    if (errors == 0) begin
      $display("linear_probe_hash_table_top verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("linear_probe_hash_table_top verification failed");
    end
    $finish;
  end

endmodule
